// ===== hdl/json_top_level_pair_tagger_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the top-level pair tagger.
// Each macro checks a property on the rising edge of clk.
// ----------------------------------------------------------------------------
`ifndef JSON_TOP_LEVEL_PAIR_TAGGER_MACROS_SVH
`define JSON_TOP_LEVEL_PAIR_TAGGER_MACROS_SVH

`ifndef ASSERT_OFF
// Checks a property outside reset.
`define JTP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Checks a property at every edge, reset included.
`define JTP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define JTP_ASSERT(lbl, prop, msg)
`define JTP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/jtpt_pkg.sv =====
// ----------------------------------------------------------------------------
// jtpt_pkg
// Types and constants shared by the top-level pair tagger.
// ----------------------------------------------------------------------------
package jtpt_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  localparam logic [7:0] CH_COLON     = 8'h3A;
  localparam logic [7:0] CH_COMMA     = 8'h2C;
  localparam logic [7:0] CH_LSQUARE   = 8'h5B;
  localparam logic [7:0] CH_RSQUARE   = 8'h5D;
  localparam logic [7:0] CH_LCURLY    = 8'h7B;
  localparam logic [7:0] CH_RCURLY    = 8'h7D;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;

  typedef enum logic [1:0] {
    SYM_QUOTE  = 2'd0,
    SYM_SQUARE = 2'd1,
    SYM_CURLY  = 2'd2,
    SYM_NONE   = 2'd3
  } sym_t;

  typedef enum logic [2:0] {
    KIND_DROP      = 3'd0,
    KIND_KEY       = 3'd1,
    KIND_VALUE     = 3'd2,
    KIND_KEY_END   = 3'd3,
    KIND_VALUE_END = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    STK_HOLD = 2'd0,
    STK_PUSH = 2'd1,
    STK_POP  = 2'd2
  } stk_op_t;

  typedef struct packed {
    logic [7:0] data;
    kind_t      kind;
    logic       ovf;
  } res_t;

endpackage

// ===== hdl/json_top_level_pair_tagger.sv =====
// ----------------------------------------------------------------------------
// json_top_level_pair_tagger
// Tags each byte of a JSON text as key, value, key end, value end or dropped.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_byte, doc_start) carries one
// byte of the text per transaction. Setting doc_start clears the parse state
// before that byte is processed.
// The output channel (out_valid, out_ready, out_byte, byte_kind,
// stack_overflow) returns exactly one result transaction per input byte,
// in order.
// Results are registered in the output register. Throughput is one byte per
// cycle while the receiver keeps out_ready high, set by the nesting stack
// update; its top two entries sit at fixed places in a shift register.
// When the receiver stalls, one further byte is taken into a skid register,
// and in_ready then drops until the output register drains.
// A synchronous reset on rst clears the parse state and empties both result
// registers; no result is pending after reset.
// ----------------------------------------------------------------------------
`include "json_top_level_pair_tagger_macros.svh"

module json_top_level_pair_tagger
  import jtpt_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       doc_start,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] byte_kind,
  output logic       stack_overflow
);

  localparam int CW = $clog2(STACK_DEPTH + 1);

  sym_t          stk [STACK_DEPTH];
  logic [CW-1:0] count;
  logic          in_key_quote;
  logic          in_value;
  logic          skip_next;

  logic [CW-1:0] count_next;
  logic          in_key_quote_next;
  logic          in_value_next;
  logic          skip_next_next;

  res_t res_main;
  res_t res_skid;
  logic skid_valid;

  logic          acc;
  logic          take;
  logic [CW-1:0] c;
  logic          ikq;
  logic          iv;
  logic          sk;
  sym_t          p0;
  sym_t          p1;
  kind_t         kind;
  kind_t         carried;
  logic          ovf;
  stk_op_t       op;
  sym_t          psym;
  logic          pop_closer;
  logic [CW-1:0] c_post;
  res_t          res_new;

  assign in_ready = !skid_valid;
  assign acc      = in_valid && in_ready;
  assign take     = out_valid && out_ready;

  always_comb begin
    c   = doc_start ? '0 : count;
    ikq = doc_start ? 1'b0 : in_key_quote;
    iv  = doc_start ? 1'b0 : in_value;
    sk  = doc_start ? 1'b0 : skip_next;
    p0  = (c > CW'(0)) ? stk[0] : SYM_NONE;
    p1  = (c > CW'(1)) ? stk[1] : SYM_NONE;
    carried = iv ? KIND_VALUE : KIND_KEY;

    kind = KIND_DROP;
    op   = STK_HOLD;
    psym = SYM_QUOTE;
    in_key_quote_next = ikq;
    in_value_next     = iv;
    skip_next_next    = sk;
    pop_closer = 1'b0;
    c_post     = c;

    if (sk) begin
      skip_next_next = 1'b0;
    end else if (in_byte == CH_BACKSLASH) begin
      skip_next_next = 1'b1;
    end else if (in_byte == CH_QUOTE) begin
      if (ikq && (c != '0)) begin
        if (!iv && (p0 == SYM_QUOTE)) begin
          if (p1 != SYM_QUOTE) begin
            in_key_quote_next = 1'b0;
          end else begin
            kind = carried;
          end
          op = STK_POP;
        end else begin
          kind = carried;
          op = (p0 == SYM_QUOTE) ? STK_POP : STK_PUSH;
        end
      end else begin
        if (!iv) begin
          in_key_quote_next = 1'b1;
        end else begin
          kind = KIND_VALUE;
        end
        op = (p0 != SYM_QUOTE) ? STK_PUSH : STK_POP;
      end
    end else if ((in_byte == CH_LSQUARE) || (in_byte == CH_LCURLY)) begin
      op   = STK_PUSH;
      psym = (in_byte == CH_LSQUARE) ? SYM_SQUARE : SYM_CURLY;
      if (iv) begin
        kind = KIND_VALUE;
      end
    end else begin
      pop_closer = ((in_byte == CH_RSQUARE) && (p0 == SYM_SQUARE)) ||
                   ((in_byte == CH_RCURLY) && (p0 == SYM_CURLY));
      if (pop_closer) begin
        op     = STK_POP;
        c_post = c - CW'(1);
      end
      if (!iv && !ikq) begin
        if ((in_byte == CH_COLON) && (c_post == CW'(1))) begin
          in_value_next = 1'b1;
          kind = KIND_KEY_END;
        end
      end else if (iv && (((c_post == CW'(1)) && (in_byte == CH_COMMA)) ||
                          ((c_post == '0) && ((in_byte == CH_RCURLY) ||
                                              (in_byte == CH_RSQUARE))))) begin
        in_value_next = 1'b0;
        kind = KIND_VALUE_END;
      end else begin
        kind = carried;
      end
    end

    ovf = (op == STK_PUSH) && (c >= CW'(STACK_DEPTH));
    count_next = c;
    if ((op == STK_PUSH) && !ovf) begin
      count_next = c + CW'(1);
    end else if ((op == STK_POP) && (c != '0)) begin
      count_next = c - CW'(1);
    end

    res_new.data = in_byte;
    res_new.kind = kind;
    res_new.ovf  = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      in_key_quote <= 1'b0;
      in_value     <= 1'b0;
      skip_next    <= 1'b0;
    end else if (acc) begin
      count        <= count_next;
      in_key_quote <= in_key_quote_next;
      in_value     <= in_value_next;
      skip_next    <= skip_next_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      if ((op == STK_PUSH) && !ovf) begin
        stk[0] <= psym;
        for (int i = 1; i < STACK_DEPTH; i++) begin
          stk[i] <= stk[i-1];
        end
      end else if ((op == STK_POP) && (c != '0)) begin
        for (int i = 0; i < STACK_DEPTH - 1; i++) begin
          stk[i] <= stk[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (acc) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        res_main <= res_skid;
      end
    end else if (acc) begin
      if (!out_valid || take) begin
        res_main <= res_new;
      end else begin
        res_skid <= res_new;
      end
    end
  end

  assign out_byte       = res_main.data;
  assign byte_kind      = res_main.kind;
  assign stack_overflow = res_main.ovf;

  `JTP_ASSERT(a_count_bound, count <= CW'(STACK_DEPTH), "stack count beyond depth")
  `JTP_ASSERT(a_flags_exclusive, !(in_value && in_key_quote), "key quote inside value")
  `JTP_ASSERT(a_escape_keeps_stack, acc && skip_next && !doc_start |=> count == $past(count),
              "escaped byte changed the stack")
  `JTP_ASSERT_ALWAYS(a_skid_behind_main, skid_valid |-> out_valid, "skid full, output empty")
  `JTP_ASSERT(a_accept_gives_result, acc |=> out_valid, "accepted byte gave no result")

endmodule

// ===== bench/tb_json_top_level_pair_tagger.sv =====
// ----------------------------------------------------------------------------
// Testbench for json_top_level_pair_tagger
// Feeds short directed texts and then randomly generated JSON documents
// (well-formed, corrupted and noise) through the byte channel. A local model
// of the nesting stack and parse flags predicts the tag of every accepted
// byte, and each result transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_json_top_level_pair_tagger
  import jtpt_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_CYCLES = 80;
  localparam int TARGET_ITEMS = 1200;

  typedef enum int { PH_RX_HEAVY, PH_TX_HEAVY, PH_STEADY } tb_phase_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } text_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       doc_start = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] byte_kind;
  logic       stack_overflow;

  text_item_t text_q[$];
  res_t       tag_q[$];
  int         n_total = 0;
  int         n_issued = 0;
  int         n_mismatch = 0;
  int         idle_cycles = 0;
  int         hold_left = 0;
  bit         hold_done = 1'b0;

  sym_t        nest_stk[STACK_DEPTH_DEF];
  int unsigned nest_cnt;
  bit          key_open;
  bit          value_open;
  bit          escape_pending;

  always #5 clk = ~clk;

  json_top_level_pair_tagger u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .doc_start      (doc_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .byte_kind      (byte_kind),
    .stack_overflow (stack_overflow)
  );

  function automatic void parse_clear();
    nest_cnt = 0;
    key_open = 1'b0;
    value_open = 1'b0;
    escape_pending = 1'b0;
  endfunction

  function automatic sym_t nest_peek(int unsigned below);
    if (nest_cnt <= below) return SYM_NONE;
    return nest_stk[nest_cnt - 1 - below];
  endfunction

  function automatic bit nest_push(sym_t s);
    if (nest_cnt >= STACK_DEPTH_DEF) return 1'b1;
    nest_stk[nest_cnt] = s;
    nest_cnt++;
    return 1'b0;
  endfunction

  function automatic void nest_pop();
    if (nest_cnt > 0) nest_cnt--;
  endfunction

  function automatic res_t tag_byte(logic [7:0] b, logic clear);
    kind_t k;
    kind_t carried;
    bit    ovf;
    k = KIND_DROP;
    ovf = 1'b0;
    if (clear) parse_clear();
    carried = value_open ? KIND_VALUE : KIND_KEY;
    if (escape_pending) begin
      escape_pending = 1'b0;
    end else if (b == CH_BACKSLASH) begin
      escape_pending = 1'b1;
    end else if (b == CH_QUOTE) begin
      if (key_open && nest_cnt > 0) begin
        if (!value_open && nest_peek(0) == SYM_QUOTE) begin
          if (nest_peek(1) != SYM_QUOTE) key_open = 1'b0;
          else k = carried;
          nest_pop();
        end else begin
          k = carried;
          if (nest_peek(0) == SYM_QUOTE) nest_pop();
          else ovf = nest_push(SYM_QUOTE);
        end
      end else begin
        if (!value_open) key_open = 1'b1;
        else k = KIND_VALUE;
        if (nest_peek(0) != SYM_QUOTE) ovf = nest_push(SYM_QUOTE);
        else nest_pop();
      end
    end else if (b == CH_LSQUARE || b == CH_LCURLY) begin
      ovf = nest_push(b == CH_LSQUARE ? SYM_SQUARE : SYM_CURLY);
      if (value_open) k = KIND_VALUE;
    end else begin
      if (b == CH_RSQUARE && nest_peek(0) == SYM_SQUARE) nest_pop();
      else if (b == CH_RCURLY && nest_peek(0) == SYM_CURLY) nest_pop();
      if (!value_open && !key_open) begin
        if (b == CH_COLON && nest_cnt == 1) begin
          value_open = 1'b1;
          k = KIND_KEY_END;
        end
      end else if (value_open && ((nest_cnt == 1 && b == CH_COMMA) ||
                   (nest_cnt == 0 && (b == CH_RCURLY || b == CH_RSQUARE)))) begin
        value_open = 1'b0;
        k = KIND_VALUE_END;
      end else begin
        k = carried;
      end
    end
    return '{data: b, kind: k, ovf: ovf};
  endfunction

  function automatic void put(logic [7:0] b);
    text_q.push_back('{ch: b, first: 1'b0});
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic void put_chars(bit quoted_body);
    int n;
    n = $urandom_range(0, 5);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: begin
          put(CH_BACKSLASH);
          put(8'($urandom_range(0, 255)));
        end
        1: begin
          if (quoted_body) put(CH_RCURLY);
          else put(CH_COLON);
        end
        2: begin
          if (quoted_body) put(CH_COMMA);
          else put(CH_LSQUARE);
        end
        default: put(8'($urandom_range(8'h61, 8'h7A)));
      endcase
    end
  endfunction

  function automatic void gen_key();
    put(CH_QUOTE);
    put_chars(1'b0);
    put(CH_QUOTE);
  endfunction

  function automatic void gen_object(int lvl);
    int n;
    n = $urandom_range(0, 3);
    put(CH_LCURLY);
    for (int i = 0; i < n; i++) begin
      if (i > 0) put(CH_COMMA);
      gen_key();
      put(CH_COLON);
      gen_value(lvl + 1);
    end
    put(CH_RCURLY);
  endfunction

  function automatic void gen_value(int lvl);
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) put(8'($urandom_range(8'h30, 8'h39)));
      end
      3, 4: begin
        put(CH_QUOTE);
        put_chars(1'b1);
        put(CH_QUOTE);
      end
      5, 6: begin
        if (lvl < 4) begin
          n = $urandom_range(0, 3);
          put(CH_LSQUARE);
          for (int i = 0; i < n; i++) begin
            if (i > 0) put(CH_COMMA);
            gen_value(lvl + 1);
          end
          put(CH_RSQUARE);
        end else begin
          put_text("null");
        end
      end
      7, 8: begin
        if (lvl < 4) gen_object(lvl);
        else put_text("true");
      end
      default: begin
        // Deep nesting runs past the stack so that pushes get dropped.
        n = $urandom_range(12, 20);
        for (int i = 0; i < n; i++) put($urandom_range(0, 1) ? CH_LSQUARE : CH_LCURLY);
        for (int i = 0; i < n; i++) put($urandom_range(0, 1) ? CH_RSQUARE : CH_RCURLY);
      end
    endcase
  endfunction

  function automatic void gen_document();
    int start;
    int mode;
    int n;
    start = text_q.size();
    mode = $urandom_range(0, 9);
    if (mode == 8) begin
      n = $urandom_range(5, 30);
      for (int i = 0; i < n; i++)
        text_q.push_back('{ch: 8'($urandom_range(0, 255)),
                           first: ($urandom_range(0, 7) == 0)});
    end else begin
      gen_object(0);
      if (mode != 9) text_q[start].first = 1'b1;
      if (mode == 7) begin
        for (int i = start; i < text_q.size(); i++) begin
          if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 7))
              0: text_q[i].ch = CH_COLON;
              1: text_q[i].ch = CH_COMMA;
              2: text_q[i].ch = CH_QUOTE;
              3: text_q[i].ch = CH_RCURLY;
              4: text_q[i].ch = CH_RSQUARE;
              5: text_q[i].ch = CH_BACKSLASH;
              default: text_q[i].ch = 8'($urandom_range(0, 255));
            endcase
          end
        end
        n = $urandom_range(0, text_q.size() - start - 1);
        while (n > 0) begin
          void'(text_q.pop_back());
          n--;
        end
      end
    end
  endfunction

  function automatic tb_phase_t cur_phase();
    if (n_issued * 3 < n_total) return PH_RX_HEAVY;
    if (n_issued * 3 < n_total * 2) return PH_TX_HEAVY;
    return PH_STEADY;
  endfunction

  always @(posedge clk) begin : driver
    text_item_t nxt;
    int         idle_pct;
    if (rst) begin
      in_valid <= 1'b0;
      parse_clear();
    end else begin
      if (in_valid && in_ready) tag_q.push_back(tag_byte(in_byte, doc_start));
      if (!in_valid || in_ready) begin
        case (cur_phase())
          PH_RX_HEAVY: idle_pct = 35;
          PH_TX_HEAVY: idle_pct = 59;
          default:     idle_pct = 0;
        endcase
        if (text_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          nxt = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= nxt.ch;
          doc_start <= nxt.first;
          n_issued <= n_issued + 1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : receiver
    int stall_pct;
    case (cur_phase())
      PH_RX_HEAVY: stall_pct = 59;
      PH_TX_HEAVY: stall_pct = 35;
      default:     stall_pct = 0;
    endcase
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (cur_phase() == PH_STEADY && !hold_done) begin
      // A long hold-off lets the block back up and stall its input.
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst && out_valid && out_ready) begin
      if (tag_q.size() == 0) begin
        if (n_mismatch < 10)
          $display("ERROR: unexpected result byte=%h kind=%0d ovf=%0d",
                   out_byte, byte_kind, stack_overflow);
        n_mismatch++;
      end else begin
        want = tag_q.pop_front();
        if (out_byte !== want.data || byte_kind !== want.kind ||
            stack_overflow !== want.ovf) begin
          if (n_mismatch < 10)
            $display("ERROR: expected byte=%h kind=%0d ovf=%0d, got byte=%h kind=%0d ovf=%0d",
                     want.data, want.kind, want.ovf, out_byte, byte_kind, stack_overflow);
          n_mismatch++;
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL json_top_level_pair_tagger");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    text_q.push_back('{ch: 8'h00, first: 1'b1});
    text_q.push_back('{ch: 8'hFF, first: 1'b0});
    put_text("]\"a\\\"\":{\"b\":[}1]},\"c\":9}");
    text_q[2].first = 1'b1;
    while (text_q.size() < TARGET_ITEMS) gen_document();
    n_total = text_q.size();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (text_q.size() != 0 || in_valid || tag_q.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (n_mismatch == 0 && tag_q.size() == 0) begin
      $display("PASS json_top_level_pair_tagger");
    end else begin
      $display("FAIL json_top_level_pair_tagger");
    end
    $finish;
  end

endmodule
